@@ sv/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants, types and the arctangent table for the
// quaternion to euler angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

    // fixed point of the products and sums
    localparam int FRAC_Q   = 30;
    localparam int SUM_W    = 36;
    // radicand and root of the pitch cosine
    localparam int RAD_W    = 61;
    localparam int RES_W    = 62;
    localparam int ROOT_W   = 31;
    localparam int ROOT_LAT = 31;
    // vectoring unit
    localparam int NORM_EXP = 40;
    localparam int NORM_W   = 42;
    localparam int POS_W    = 6;
    localparam int CW       = 45;
    localparam int ZW       = 34;
    localparam int STEPS    = 31;
    localparam int CORD_LAT = STEPS + 3;
    localparam int FRONT_LAT = 4;

    // sine and cosine terms of the three angles
    typedef struct packed {
        logic signed [SUM_W-1:0] sr;
        logic signed [SUM_W-1:0] cr;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cy;
        logic signed [SUM_W-1:0] sp;
        logic                    sat_pos;
        logic                    sat_neg;
    } t_front;

    // atan(2^-i), pi = 2^31
    function automatic logic [31:0] f_atan(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ sv/qte_front.sv @@
// ----------------------------------------------------------------------------
// qte_front
// Component products, the sine and cosine sums and the pitch radicand,
// four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_front #(
    parameter int QUAT_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_en,
    input  wire signed [QUAT_BITS-1:0]       i_w,
    input  wire signed [QUAT_BITS-1:0]       i_x,
    input  wire signed [QUAT_BITS-1:0]       i_y,
    input  wire signed [QUAT_BITS-1:0]       i_z,
    output qte_pkg::t_front                  o_front,
    output logic [qte_pkg::RAD_W-1:0]        o_rad
);

    localparam int FRAC_P = 2 * (QUAT_BITS - 1);
    localparam int SHR    = (FRAC_P >= qte_pkg::FRAC_Q) ? FRAC_P - qte_pkg::FRAC_Q : 0;
    localparam int SHL    = (FRAC_P < qte_pkg::FRAC_Q) ? qte_pkg::FRAC_Q - FRAC_P : 0;
    localparam int SW     = qte_pkg::SUM_W;

    // product brought to Q.30 with floor
    function automatic logic signed [SW-1:0] f_q30(input logic signed [2*QUAT_BITS-1:0] p);
        logic signed [63:0] e;
        e = 64'(p);
        e = (e >>> SHR) <<< SHL;
        return e[SW-1:0];
    endfunction

    logic signed [SW-1:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    logic signed [SW-1:0] r_sr, r_cr, r_sy, r_cy, r_sp;
    logic signed [SW-1:0] one_q;
    logic signed [30:0]   sp_short;
    logic signed [61:0]   sq;
    logic [qte_pkg::RAD_W-1:0] r_sq;
    qte_pkg::t_front      r_f3;
    qte_pkg::t_front      r_f4;
    logic [qte_pkg::RAD_W-1:0] r_rad;

    assign one_q = SW'(64'sd1 <<< qte_pkg::FRAC_Q);

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= f_q30(i_w * i_x);
            r_yz <= f_q30(i_y * i_z);
            r_xx <= f_q30(i_x * i_x);
            r_yy <= f_q30(i_y * i_y);
            r_wz <= f_q30(i_w * i_z);
            r_xy <= f_q30(i_x * i_y);
            r_zz <= f_q30(i_z * i_z);
            r_wy <= f_q30(i_w * i_y);
            r_zx <= f_q30(i_z * i_x);
        end
    end

    // stage 2: sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr <= (r_wx + r_yz) <<< 1;
            r_cr <= one_q - ((r_xx + r_yy) <<< 1);
            r_sy <= (r_wz + r_xy) <<< 1;
            r_cy <= one_q - ((r_yy + r_zz) <<< 1);
            r_sp <= (r_wy - r_zx) <<< 1;
        end
    end

    // stage 3: pitch saturation and square of the sine
    assign sp_short = r_sp[30:0];
    assign sq       = sp_short * sp_short;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f3.sr      <= r_sr;
            r_f3.cr      <= r_cr;
            r_f3.sy      <= r_sy;
            r_f3.cy      <= r_cy;
            r_f3.sp      <= r_sp;
            r_f3.sat_pos <= (r_sp >= one_q);
            r_f3.sat_neg <= (r_sp <= -one_q);
            r_sq         <= sq[qte_pkg::RAD_W-1:0];
        end
    end

    // stage 4: radicand of the cosine
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f4  <= r_f3;
            r_rad <= (qte_pkg::RAD_W'(1) << 60) - r_sq;
        end
    end

    assign o_front = r_f4;
    assign o_rad   = r_rad;

endmodule

`default_nettype wire

@@ sv/qte_isqrt.sv @@
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_isqrt (
    input  wire                               i_clk,
    input  wire                               i_en,
    input  wire  [qte_pkg::RAD_W-1:0]         i_rad,
    output logic [qte_pkg::ROOT_W-1:0]        o_root
);

    localparam int N = qte_pkg::ROOT_LAT;

    logic [qte_pkg::RAD_W-1:0] r_rem [0:N];
    logic [qte_pkg::RES_W-1:0] r_res [0:N];

    assign r_rem[0] = i_rad;
    assign r_res[0] = '0;

    // one restoring step per stage, trial bit 4^(N-1-g)
    for (genvar g = 0; g < N; g++) begin : g_step
        localparam int K = N - 1 - g;
        logic [qte_pkg::RES_W-1:0] bitv;
        logic [qte_pkg::RES_W-1:0] trial;
        logic                      take;

        assign bitv  = qte_pkg::RES_W'(1) << (2 * K);
        assign trial = r_res[g] + bitv;
        assign take  = {1'b0, r_rem[g]} >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (take) begin
                    r_rem[g+1] <= r_rem[g] - trial[qte_pkg::RAD_W-1:0];
                    r_res[g+1] <= (r_res[g] >> 1) + bitv;
                end else begin
                    r_rem[g+1] <= r_rem[g];
                    r_res[g+1] <= r_res[g] >> 1;
                end
            end
        end
    end

    assign o_root = r_res[N][qte_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

@@ sv/qte_cordic.sv @@
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined atan2: leading-one search, normalising shift, quadrant turn
// and 31 vectoring stages.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic (
    input  wire                                  i_clk,
    input  wire                                  i_en,
    input  wire signed [qte_pkg::SUM_W-1:0]      i_y,
    input  wire signed [qte_pkg::SUM_W-1:0]      i_x,
    output logic signed [qte_pkg::ZW-1:0]        o_z
);

    localparam int SW = qte_pkg::SUM_W;
    localparam int CW = qte_pkg::CW;
    localparam int ZW = qte_pkg::ZW;
    localparam int NS = qte_pkg::STEPS;

    logic [SW-1:0]              ax, ay, am;
    logic [qte_pkg::POS_W-1:0]  pos;
    logic signed [SW-1:0]       r_a_x, r_a_y;
    logic [qte_pkg::POS_W-1:0]  r_a_pos;
    logic                       r_a_zero;
    logic [qte_pkg::POS_W-1:0]  sh;
    logic signed [qte_pkg::NORM_W-1:0] r_b_x, r_b_y;
    logic                       r_b_zero;
    logic signed [CW-1:0]       bx, by;
    logic signed [CW-1:0]       r_x [0:NS];
    logic signed [CW-1:0]       r_y [0:NS];
    logic signed [ZW-1:0]       r_z [0:NS];
    logic                       r_zf [0:NS];

    // stage a: leading one of the larger magnitude
    assign ax = i_x[SW-1] ? SW'(-i_x) : SW'(i_x);
    assign ay = i_y[SW-1] ? SW'(-i_y) : SW'(i_y);
    assign am = ax | ay;

    always_comb begin
        pos = '0;
        for (int b = 0; b < SW; b++) begin
            if (am[b]) begin
                pos = qte_pkg::POS_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x    <= i_x;
            r_a_y    <= i_y;
            r_a_pos  <= pos;
            r_a_zero <= (am == '0);
        end
    end

    // stage b: normalise so the larger magnitude reaches 2^40
    assign sh = qte_pkg::POS_W'(qte_pkg::NORM_EXP) - r_a_pos;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_x    <= qte_pkg::NORM_W'(r_a_x) <<< sh;
            r_b_y    <= qte_pkg::NORM_W'(r_a_y) <<< sh;
            r_b_zero <= r_a_zero;
        end
    end

    // stage c: turn the left half plane by a quarter
    assign bx = CW'(r_b_x);
    assign by = CW'(r_b_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zf[0] <= r_b_zero;
            if (!bx[CW-1]) begin
                r_x[0] <= bx;
                r_y[0] <= by;
                r_z[0] <= '0;
            end else if (!by[CW-1]) begin
                r_x[0] <= by;
                r_y[0] <= -bx;
                r_z[0] <= ZW'(64'sd1 <<< 30);
            end else begin
                r_x[0] <= -by;
                r_y[0] <= bx;
                r_z[0] <= -ZW'(64'sd1 <<< 30);
            end
        end
    end

    // vectoring stages
    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic signed [ZW-1:0] ang;
        assign ang = ZW'(qte_pkg::f_atan(g));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zf[g+1] <= r_zf[g];
                if (!r_y[g][CW-1]) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + ang;
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - ang;
                end
            end
        end
    end

    // zero vector reads as angle zero
    assign o_z = r_zf[NS] ? '0 : r_z[NS];

endmodule

`default_nettype wire

@@ sv/quaternion_to_euler_angles.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Unit quaternion in, roll, pitch and yaw (ZYX) out as binary angles.
// ----------------------------------------------------------------------------
// The block accepts one word every clock while the output side does not stall
// and returns one word per input word in order, through these stages:
// 4 stages form the products and sums, 31 stages take the square root for the
// pitch cosine, 34 stages run the three CORDIC arctangents side by side and
// one register holds the rounded result. A stall on the output freezes the
// whole pipeline, so the input is ready whenever the output register is empty
// or being taken. Angles are signed with 2^(ANGLE_BITS-1) standing for pi;
// pitch saturates at a quarter turn.
`default_nettype none

module quaternion_to_euler_angles #(
    parameter int QUAT_BITS  = 16,
    parameter int ANGLE_BITS = 16
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      s_axis_tvalid,
    output logic                                     s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, zero fill
    input  wire  [((4*QUAT_BITS+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire                                      m_axis_tready,
    // roll_angle, pitch_angle, yaw_angle, zero fill
    output logic [((3*ANGLE_BITS+7)/8)*8-1:0]        m_axis_tdata
);

    localparam int OUT_W = ((3*ANGLE_BITS+7)/8)*8;
    localparam int LAT   = qte_pkg::FRONT_LAT + qte_pkg::ROOT_LAT + qte_pkg::CORD_LAT;
    localparam int SH    = 32 - ANGLE_BITS;
    localparam int ZW    = qte_pkg::ZW;

    logic                         en;
    logic                         r_vld [0:LAT-1];
    qte_pkg::t_front              front;
    logic [qte_pkg::RAD_W-1:0]    rad;
    logic [qte_pkg::ROOT_W-1:0]   root;
    qte_pkg::t_front              r_dly [0:qte_pkg::ROOT_LAT-1];
    logic [1:0]                   r_sat [0:qte_pkg::CORD_LAT-1];
    logic signed [ZW-1:0]         z_roll, z_pitch, z_yaw, z_pitch_sel;
    logic [ANGLE_BITS-1:0]        a_roll, a_pitch, a_yaw;
    logic                         r_out_valid;
    logic [3*ANGLE_BITS-1:0]      r_out;

    // whole pipeline advances together
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    qte_front #(.QUAT_BITS(QUAT_BITS)) u_front (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_w     (s_axis_tdata[QUAT_BITS-1:0]),
        .i_x     (s_axis_tdata[2*QUAT_BITS-1:QUAT_BITS]),
        .i_y     (s_axis_tdata[3*QUAT_BITS-1:2*QUAT_BITS]),
        .i_z     (s_axis_tdata[4*QUAT_BITS-1:3*QUAT_BITS]),
        .o_front (front),
        .o_rad   (rad)
    );

    qte_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (rad),
        .o_root (root)
    );

    // terms wait alongside the square root
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= front;
            for (int i = 1; i < qte_pkg::ROOT_LAT; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    qte_cordic u_roll (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_dly[qte_pkg::ROOT_LAT-1].sr),
        .i_x   (r_dly[qte_pkg::ROOT_LAT-1].cr),
        .o_z   (z_roll)
    );

    qte_cordic u_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_dly[qte_pkg::ROOT_LAT-1].sp),
        .i_x   (qte_pkg::SUM_W'(root)),
        .o_z   (z_pitch)
    );

    qte_cordic u_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_dly[qte_pkg::ROOT_LAT-1].sy),
        .i_x   (r_dly[qte_pkg::ROOT_LAT-1].cy),
        .o_z   (z_yaw)
    );

    // saturation flags wait alongside the arctangent
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sat[0] <= {r_dly[qte_pkg::ROOT_LAT-1].sat_pos,
                         r_dly[qte_pkg::ROOT_LAT-1].sat_neg};
            for (int i = 1; i < qte_pkg::CORD_LAT; i++) begin
                r_sat[i] <= r_sat[i-1];
            end
        end
    end

    always_comb begin
        if (r_sat[qte_pkg::CORD_LAT-1][1]) begin
            z_pitch_sel = ZW'(64'sd1 <<< 30);
        end else if (r_sat[qte_pkg::CORD_LAT-1][0]) begin
            z_pitch_sel = -ZW'(64'sd1 <<< 30);
        end else begin
            z_pitch_sel = z_pitch;
        end
    end

    // round the 32-bit angle to the output width
    if (SH > 0) begin : g_round
        logic signed [ZW-1:0] t_roll, t_pitch, t_yaw;
        assign t_roll  = z_roll + ZW'(64'sd1 <<< (SH - 1));
        assign t_pitch = z_pitch_sel + ZW'(64'sd1 <<< (SH - 1));
        assign t_yaw   = z_yaw + ZW'(64'sd1 <<< (SH - 1));
        assign a_roll  = t_roll[SH+ANGLE_BITS-1:SH];
        assign a_pitch = t_pitch[SH+ANGLE_BITS-1:SH];
        assign a_yaw   = t_yaw[SH+ANGLE_BITS-1:SH];
    end else begin : g_plain
        assign a_roll  = z_roll[ANGLE_BITS-1:0];
        assign a_pitch = z_pitch_sel[ANGLE_BITS-1:0];
        assign a_yaw   = z_yaw[ANGLE_BITS-1:0];
    end

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int i = 1; i < LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_out_valid <= r_vld[LAT-1];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= {a_yaw, a_pitch, a_roll};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out);

`ifndef SYNTH
    // pitch never exceeds a quarter turn
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS])
                <= $signed(ANGLE_BITS'(1) << (ANGLE_BITS - 2))) &&
            ($signed(m_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS])
                >= -$signed(ANGLE_BITS'(1) << (ANGLE_BITS - 2))))
        else $error("pitch out of range");

    // positive saturation lands as a quarter turn
    a_sat_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[LAT-1] && r_sat[qte_pkg::CORD_LAT-1][1]) |=>
            (m_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]
                == (ANGLE_BITS'(1) << (ANGLE_BITS - 2))))
        else $error("pitch saturation lost");

    // no word straight after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire
